### hw/rtl/adsr_pkg.sv
// Shared types and constants for the ADSR envelope shaper.
// Holds the configuration record, register indexes, phase codes and level format.
// No dependencies; the modules and the testbench import this package.
package adsr_pkg;

	// Level format: unsigned, 2 integer bits and 24 fraction bits.
	localparam int LEVEL_W = 26;
	localparam int FRAC_W = 24;
	localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << FRAC_W;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

	// Configuration port geometry.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 25;
	localparam int LEN_W = 16;
	localparam int PEAK_W = 25;
	localparam int SLOPE_W = 24;
	localparam int DSLOPE_W = 25;

	// Register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_SAMPLES = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DECAY_SAMPLES = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SUSTAIN_SAMPLES = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_SAMPLES = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_PEAK_LEVEL = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_SLOPE = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_DECAY_SLOPE = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_SLOPE = 3'd7;

	// Register reset values.
	localparam logic [LEN_W-1:0] RST_ATTACK_SAMPLES = 16'd960;
	localparam logic [LEN_W-1:0] RST_DECAY_SAMPLES = 16'd480;
	localparam logic [LEN_W-1:0] RST_SUSTAIN_SAMPLES = 16'd48000;
	localparam logic [LEN_W-1:0] RST_RELEASE_SAMPLES = 16'd4800;
	localparam logic [PEAK_W-1:0] RST_PEAK_LEVEL = 25'd18454938;
	localparam logic [SLOPE_W-1:0] RST_ATTACK_SLOPE = 24'd19223;
	localparam logic [DSLOPE_W-1:0] RST_DECAY_SLOPE = 25'h1FFF259; // -3495
	localparam logic [SLOPE_W-1:0] RST_RELEASE_SLOPE = 24'd3495;

	// Envelope phase codes.
	localparam logic [1:0] PH_ATTACK = 2'd0;
	localparam logic [1:0] PH_DECAY = 2'd1;
	localparam logic [1:0] PH_SUSTAIN = 2'd2;
	localparam logic [1:0] PH_RELEASE = 2'd3;

	// Configuration record; decay_slope holds a two's complement value.
	typedef struct packed {
		logic [LEN_W-1:0] attack_samples;
		logic [LEN_W-1:0] decay_samples;
		logic [LEN_W-1:0] sustain_samples;
		logic [LEN_W-1:0] release_samples;
		logic [PEAK_W-1:0] peak_level;
		logic [SLOPE_W-1:0] attack_slope;
		logic [DSLOPE_W-1:0] decay_slope;
		logic [SLOPE_W-1:0] release_slope;
	} adsr_cfg_t;

	// Tag that travels with each sample through the pipeline.
	typedef struct packed {
		logic [1:0] phase;
		logic last;
	} adsr_tag_t;

endpackage

### hw/rtl/adsr_in_if.sv
// Input channel of the ADSR envelope shaper: valid/ready plus sample payload.
// Standalone interface; widths follow SAMPLE_WIDTH.
interface adsr_in_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH-1:0] in_sample;
	logic note_start;

	modport source (output valid, output in_sample, output note_start, input ready);
	modport sink (input valid, input in_sample, input note_start, output ready);
endinterface

### hw/rtl/adsr_out_if.sv
// Output channel of the ADSR envelope shaper: valid/ready plus shaped payload.
// Standalone interface; widths follow SAMPLE_WIDTH.
interface adsr_out_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH-1:0] out_sample;
	logic [1:0] env_phase;
	logic last_sample;

	modport source (output valid, output out_sample, output env_phase, output last_sample,
		input ready);
	modport sink (input valid, input out_sample, input env_phase, input last_sample,
		output ready);
endinterface

### hw/rtl/adsr_envelope_shaper_core.sv
// Top level of the ADSR envelope shaper.
// Depends on adsr_pkg, adsr_in_if, adsr_out_if, adsr_cfg_regs, adsr_env_seq, adsr_shape_mult.
//
// Usage:
//   Samples arrive on the audio channel (in_sample, note_start) and shaped samples
//   leave on the shaped channel (out_sample, env_phase, last_sample), both valid/ready.
//   An item is taken at a clock edge with valid and ready high. Configuration is a
//   plain write port (cfg_we, cfg_index, cfg_data); the user must write it only while the
//   block idles, which the block does not enforce. Throughput is one item per cycle while
//   the receiver takes results: the envelope update is one add and compare in stage 1,
//   and the product is one multiply with rounding and saturation into the output register.
//   An item that arrives while no envelope runs and without note start is consumed
//   and gives no result. The item carrying last_sample ends the envelope.
//   Reset (arst_n low) loads the register defaults and leaves the envelope idle; no
//   clearing pass is needed, so items are accepted as soon as reset ends.
//   When the receiver stalls, the output register holds its item; stage 1 can still
//   take one more item, and only when both stages are full does audio.ready drop.
module adsr_envelope_shaper_core
	import adsr_pkg::*;
#(
	parameter int COUNT_WIDTH = 16,
	parameter int SAMPLE_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	adsr_in_if.sink audio,
	adsr_out_if.source shaped
);

	adsr_cfg_t cfg;
	logic accept;
	logic s1_ready;
	logic s2_ready;
	logic valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic [LEVEL_W-1:0] level_s1;
	adsr_tag_t tag_s1;
	logic valid_s2;
	logic signed [SAMPLE_WIDTH-1:0] sample_s2;
	adsr_tag_t tag_s2;

	// Each stage accepts when it is empty or its contents move on.
	assign s2_ready = !valid_s2 || shaped.ready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign audio.ready = s1_ready;
	assign accept = audio.valid && s1_ready;

	adsr_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	adsr_env_seq #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.accept(accept),
		.in_sample(audio.in_sample),
		.note_start(audio.note_start),
		.s1_ready(s1_ready),
		.valid_s1(valid_s1),
		.sample_s1(sample_s1),
		.level_s1(level_s1),
		.tag_s1(tag_s1)
	);

	adsr_shape_mult #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_mult (
		.clk(clk),
		.arst_n(arst_n),
		.load(valid_s1),
		.s2_ready(s2_ready),
		.sample_s1(sample_s1),
		.level_s1(level_s1),
		.tag_s1(tag_s1),
		.valid_s2(valid_s2),
		.sample_s2(sample_s2),
		.tag_s2(tag_s2)
	);

	// Output channel driven straight from the output register.
	assign shaped.valid = valid_s2;
	assign shaped.out_sample = sample_s2;
	assign shaped.env_phase = tag_s2.phase;
	assign shaped.last_sample = tag_s2.last;

endmodule

### hw/rtl/adsr_cfg_regs.sv
// Configuration register file of the ADSR envelope shaper.
// Depends on adsr_pkg for the record type, register indexes and reset values.
module adsr_cfg_regs
	import adsr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	output adsr_cfg_t cfg
);

	adsr_cfg_t cfg_q;

	// Each write lands in one register, truncated to that register's width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_samples <= RST_ATTACK_SAMPLES;
			cfg_q.decay_samples <= RST_DECAY_SAMPLES;
			cfg_q.sustain_samples <= RST_SUSTAIN_SAMPLES;
			cfg_q.release_samples <= RST_RELEASE_SAMPLES;
			cfg_q.peak_level <= RST_PEAK_LEVEL;
			cfg_q.attack_slope <= RST_ATTACK_SLOPE;
			cfg_q.decay_slope <= RST_DECAY_SLOPE;
			cfg_q.release_slope <= RST_RELEASE_SLOPE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ATTACK_SAMPLES: cfg_q.attack_samples <= cfg_data[LEN_W-1:0];
				REG_DECAY_SAMPLES: cfg_q.decay_samples <= cfg_data[LEN_W-1:0];
				REG_SUSTAIN_SAMPLES: cfg_q.sustain_samples <= cfg_data[LEN_W-1:0];
				REG_RELEASE_SAMPLES: cfg_q.release_samples <= cfg_data[LEN_W-1:0];
				REG_PEAK_LEVEL: cfg_q.peak_level <= cfg_data[PEAK_W-1:0];
				REG_ATTACK_SLOPE: cfg_q.attack_slope <= cfg_data[SLOPE_W-1:0];
				REG_DECAY_SLOPE: cfg_q.decay_slope <= cfg_data[DSLOPE_W-1:0];
				REG_RELEASE_SLOPE: cfg_q.release_slope <= cfg_data[SLOPE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/adsr_env_seq.sv
// Envelope sequencer: phase, sample count and level state, plus the stage 1 register.
// Depends on adsr_pkg; fed by adsr_cfg_regs, feeds adsr_shape_mult.
module adsr_env_seq
	import adsr_pkg::*;
#(
	parameter int COUNT_WIDTH = 16,
	parameter int SAMPLE_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	input adsr_cfg_t cfg,
	input logic accept,
	input logic signed [SAMPLE_WIDTH-1:0] in_sample,
	input logic note_start,
	input logic s1_ready,
	output logic valid_s1,
	output logic signed [SAMPLE_WIDTH-1:0] sample_s1,
	output logic [LEVEL_W-1:0] level_s1,
	output adsr_tag_t tag_s1
);

	logic [1:0] phase_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [LEVEL_W-1:0] level_q;
	logic active_q;

	logic eff_active;
	logic [1:0] eff_phase;
	logic [COUNT_WIDTH-1:0] eff_count;
	logic [LEVEL_W-1:0] eff_level;
	logic [LEN_W-1:0] raw_len;
	logic [COUNT_WIDTH-1:0] cut_len;
	logic [COUNT_WIDTH-1:0] len;
	logic [COUNT_WIDTH:0] count_inc;
	logic phase_end;
	logic [LEVEL_W:0] att_sum;
	logic signed [LEVEL_W+1:0] dec_sum;
	logic [LEVEL_W:0] rel_diff;
	logic [1:0] phase_d;
	logic [COUNT_WIDTH-1:0] count_d;
	logic [LEVEL_W-1:0] level_d;
	logic active_d;

	// A note start restarts the envelope at attack before this sample is used.
	always_comb begin
		eff_active = note_start | active_q;
		eff_phase = note_start ? PH_ATTACK : phase_q;
		eff_count = note_start ? '0 : count_q;
		eff_level = note_start ? '0 : level_q;
	end

	// Length of the current phase, cut to the counter width; zero acts as one.
	always_comb begin
		case (eff_phase)
			PH_ATTACK: raw_len = cfg.attack_samples;
			PH_DECAY: raw_len = cfg.decay_samples;
			PH_SUSTAIN: raw_len = cfg.sustain_samples;
			default: raw_len = cfg.release_samples;
		endcase
		cut_len = COUNT_WIDTH'(raw_len);
		len = (cut_len == '0) ? COUNT_WIDTH'(1) : cut_len;
		count_inc = {1'b0, eff_count} + (COUNT_WIDTH+1)'(1);
		phase_end = (count_inc >= {1'b0, len});
	end

	// Saturating level updates for the ramping phases.
	always_comb begin
		att_sum = {1'b0, eff_level} + (LEVEL_W+1)'(cfg.attack_slope);
		dec_sum = $signed({2'b00, eff_level}) + (LEVEL_W+2)'($signed(cfg.decay_slope));
		rel_diff = {1'b0, eff_level} - (LEVEL_W+1)'(cfg.release_slope);
	end

	// Next envelope state after this sample.
	always_comb begin
		phase_d = eff_phase;
		count_d = eff_count;
		level_d = eff_level;
		active_d = eff_active;
		if (phase_end) begin
			count_d = '0;
			case (eff_phase)
				PH_ATTACK: begin
					phase_d = PH_DECAY;
					level_d = LEVEL_W'(cfg.peak_level);
				end
				PH_DECAY: begin
					phase_d = PH_SUSTAIN;
					level_d = LEVEL_ONE;
				end
				PH_SUSTAIN: begin
					phase_d = PH_RELEASE;
					level_d = LEVEL_ONE;
				end
				default: begin
					phase_d = PH_ATTACK;
					level_d = '0;
					active_d = 1'b0;
				end
			endcase
		end else begin
			count_d = count_inc[COUNT_WIDTH-1:0];
			case (eff_phase)
				PH_ATTACK: level_d = att_sum[LEVEL_W] ? LEVEL_MAX : att_sum[LEVEL_W-1:0];
				PH_DECAY: begin
					if (dec_sum[LEVEL_W+1]) begin
						level_d = '0;
					end else if (dec_sum[LEVEL_W]) begin
						level_d = LEVEL_MAX;
					end else begin
						level_d = dec_sum[LEVEL_W-1:0];
					end
				end
				PH_SUSTAIN: level_d = eff_level;
				default: level_d = rel_diff[LEVEL_W] ? '0 : rel_diff[LEVEL_W-1:0];
			endcase
		end
	end

	// Envelope state moves only on an accepted item that is active.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ATTACK;
			count_q <= '0;
			level_q <= '0;
			active_q <= 1'b0;
		end else if (accept && eff_active) begin
			phase_q <= phase_d;
			count_q <= count_d;
			level_q <= level_d;
			active_q <= active_d;
		end
	end

	// Stage 1 valid: an idle input without note start gives no result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= accept & eff_active;
		end
	end

	// Stage 1 payload: sample, the level in force before the update, and its tag.
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= in_sample;
			level_s1 <= eff_level;
			tag_s1.phase <= eff_phase;
			tag_s1.last <= (eff_phase == PH_RELEASE) && phase_end;
		end
	end

endmodule

### hw/rtl/adsr_shape_mult.sv
// Shaping stage: sample times level, rounded half up, saturated, into the output register.
// Depends on adsr_pkg; fed by adsr_env_seq.
module adsr_shape_mult
	import adsr_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic load,
	input logic s2_ready,
	input logic signed [SAMPLE_WIDTH-1:0] sample_s1,
	input logic [LEVEL_W-1:0] level_s1,
	input adsr_tag_t tag_s1,
	output logic valid_s2,
	output logic signed [SAMPLE_WIDTH-1:0] sample_s2,
	output adsr_tag_t tag_s2
);

	localparam int PROD_W = SAMPLE_WIDTH + LEVEL_W + 1;
	localparam int RES_W = PROD_W - FRAC_W;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);
	localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [RES_W-1:0] SAT_MIN = -SAT_MAX - RES_W'(1);

	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] rounded;
	logic signed [RES_W-1:0] scaled;
	logic signed [SAMPLE_WIDTH-1:0] shaped;

	// Signed multiply, add one half, floor by the fraction width, then clamp.
	always_comb begin
		prod = sample_s1 * $signed({1'b0, level_s1});
		rounded = prod + ROUND_HALF;
		scaled = rounded[PROD_W-1:FRAC_W];
		if (scaled > SAT_MAX) begin
			shaped = SAT_MAX[SAMPLE_WIDTH-1:0];
		end else if (scaled < SAT_MIN) begin
			shaped = SAT_MIN[SAMPLE_WIDTH-1:0];
		end else begin
			shaped = scaled[SAMPLE_WIDTH-1:0];
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= load;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load && s2_ready) begin
			sample_s2 <= shaped;
			tag_s2 <= tag_s1;
		end
	end

endmodule

### tb/adsr_envelope_shaper_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for adsr_envelope_shaper_core: drives audio items, predicts
// each shaped item with its own envelope model and checks results in order.
// Depends on adsr_pkg, adsr_in_if, adsr_out_if and the envelope shaper RTL.
module adsr_envelope_shaper_core_test;
	import adsr_pkg::*;

	localparam int SW = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int RESULT_GOAL = 1700;
	localparam logic signed [SW-1:0] S_MAX = 16'sh7FFF;
	localparam logic signed [SW-1:0] S_MIN = 16'sh8000;

	typedef struct packed {
		logic signed [SW-1:0] value;
		logic note;
	} audio_item_t;

	typedef struct packed {
		logic signed [SW-1:0] value;
		logic [1:0] phase;
		logic last;
	} shaped_item_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	adsr_in_if #(.SAMPLE_WIDTH(SW)) audio_ch ();
	adsr_out_if #(.SAMPLE_WIDTH(SW)) shaped_ch ();

	adsr_envelope_shaper_core #(
		.COUNT_WIDTH(16),
		.SAMPLE_WIDTH(SW)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.audio(audio_ch),
		.shaped(shaped_ch)
	);

	// Envelope model state and its copy of the registers.
	adsr_cfg_t env_cfg = '{
		attack_samples: RST_ATTACK_SAMPLES,
		decay_samples: RST_DECAY_SAMPLES,
		sustain_samples: RST_SUSTAIN_SAMPLES,
		release_samples: RST_RELEASE_SAMPLES,
		peak_level: RST_PEAK_LEVEL,
		attack_slope: RST_ATTACK_SLOPE,
		decay_slope: RST_DECAY_SLOPE,
		release_slope: RST_RELEASE_SLOPE
	};
	logic [1:0] env_step = PH_ATTACK;
	logic [LEN_W-1:0] env_count = '0;
	logic [LEVEL_W-1:0] env_level = '0;
	bit env_on = 1'b0;

	audio_item_t audio_pending[$];
	shaped_item_t shaped_expected[$];
	int items_pushed = 0;
	int items_taken = 0;
	int shaped_total = 0;
	int fault_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;

	// Clock.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Length of a phase as the block counts it: truncated, and zero acts as one.
	function automatic int phase_len(logic [1:0] ph);
		logic [LEN_W-1:0] len;
		case (ph)
			PH_ATTACK: len = env_cfg.attack_samples;
			PH_DECAY: len = env_cfg.decay_samples;
			PH_SUSTAIN: len = env_cfg.sustain_samples;
			default: len = env_cfg.release_samples;
		endcase
		return (len == 0) ? 1 : int'(len);
	endfunction

	function automatic logic [LEVEL_W-1:0] clamp_level(longint v);
		if (v < 0)
			return '0;
		if (v > longint'(LEVEL_MAX))
			return LEVEL_MAX;
		return v[LEVEL_W-1:0];
	endfunction

	// Sample times level, rounded half up, saturated to the sample width.
	function automatic logic signed [SW-1:0] scale_sample(logic signed [SW-1:0] s,
		logic [LEVEL_W-1:0] lvl);
		longint prod;
		prod = longint'(s) * longint'(lvl) + (longint'(1) <<< (FRAC_W - 1));
		prod = prod >>> FRAC_W;
		if (prod > 32767)
			return S_MAX;
		if (prod < -32768)
			return S_MIN;
		return prod[SW-1:0];
	endfunction

	// Advances the envelope by one accepted audio item.
	task automatic step_envelope(input audio_item_t it, output bit produced,
		output shaped_item_t res);
		int len;
		bit at_end;
		produced = 1'b0;
		res = '0;
		if (it.note) begin
			env_on = 1'b1;
			env_step = PH_ATTACK;
			env_count = '0;
			env_level = '0;
		end
		if (env_on) begin
			len = phase_len(env_step);
			at_end = (int'(env_count) + 1 >= len);
			produced = 1'b1;
			res.value = scale_sample(it.value, env_level);
			res.phase = env_step;
			res.last = (env_step == PH_RELEASE) && at_end;
			if (at_end) begin
				env_count = '0;
				case (env_step)
					PH_ATTACK: begin
						env_step = PH_DECAY;
						env_level = LEVEL_W'(env_cfg.peak_level);
					end
					PH_DECAY: begin
						env_step = PH_SUSTAIN;
						env_level = LEVEL_ONE;
					end
					PH_SUSTAIN: begin
						env_step = PH_RELEASE;
						env_level = LEVEL_ONE;
					end
					default: begin
						env_step = PH_ATTACK;
						env_level = '0;
						env_on = 1'b0;
					end
				endcase
			end else begin
				env_count = env_count + 1'b1;
				case (env_step)
					PH_ATTACK: env_level = clamp_level(longint'(env_level) +
						longint'(env_cfg.attack_slope));
					PH_DECAY: env_level = clamp_level(longint'(env_level) +
						longint'($signed(env_cfg.decay_slope)));
					PH_RELEASE: env_level = clamp_level(longint'(env_level) -
						longint'(env_cfg.release_slope));
					default: ;
				endcase
			end
		end
	endtask

	task automatic report_fault(string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// Audio driver: presents pending items, holding each until it is taken.
	always @(posedge clk or negedge arst_n) begin : audio_driver
		audio_item_t next_item;
		if (!arst_n) begin
			audio_ch.valid <= 1'b0;
			audio_ch.in_sample <= '0;
			audio_ch.note_start <= 1'b0;
		end else if (!audio_ch.valid || audio_ch.ready) begin
			if (audio_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = audio_pending.pop_front();
				audio_ch.valid <= 1'b1;
				audio_ch.in_sample <= next_item.value;
				audio_ch.note_start <= next_item.note;
			end else begin
				audio_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when one is requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shaped_ch.ready <= 1'b0;
		end else begin
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				shaped_ch.ready <= 1'b0;
				hold_left = hold_left - 1;
			end else begin
				shaped_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Monitor: checks each shaped item, then predicts from each accepted audio item.
	always @(posedge clk) begin : monitor
		shaped_item_t got;
		shaped_item_t want;
		shaped_item_t fresh;
		audio_item_t taken;
		bit produced;
		if (arst_n) begin
			if (shaped_ch.valid && shaped_ch.ready) begin
				got.value = shaped_ch.out_sample;
				got.phase = shaped_ch.env_phase;
				got.last = shaped_ch.last_sample;
				if (shaped_expected.size() == 0) begin
					report_fault($sformatf("unexpected item: sample %0d phase %0d last %0d",
						got.value, got.phase, got.last));
				end else begin
					want = shaped_expected.pop_front();
					if (got.value !== want.value || got.phase !== want.phase ||
						got.last !== want.last)
						report_fault($sformatf({"mismatch: expected sample %0d phase %0d ",
							"last %0d, got sample %0d phase %0d last %0d"},
							want.value, want.phase, want.last,
							got.value, got.phase, got.last));
				end
			end
			if (audio_ch.valid && audio_ch.ready) begin
				taken.value = audio_ch.in_sample;
				taken.note = audio_ch.note_start;
				step_envelope(taken, produced, fresh);
				if (produced) begin
					shaped_expected.push_back(fresh);
					shaped_total++;
				end
				items_taken++;
			end
		end
	end

	task automatic push_item(logic signed [SW-1:0] v, logic n);
		audio_item_t it;
		it.value = v;
		it.note = n;
		audio_pending.push_back(it);
		items_pushed++;
	endtask

	function automatic logic signed [SW-1:0] pick_sample();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return S_MAX;
		if (r < 20)
			return S_MIN;
		if (r < 25)
			return '0;
		if (r < 30)
			return 16'sd1;
		if (r < 35)
			return -16'sd1;
		return SW'($urandom);
	endfunction

	// Waits until every item is taken and every result has arrived, then lets
	// the pipeline empty of items that gave no result.
	task automatic settle();
		int guard;
		guard = 0;
		while ((items_taken != items_pushed || shaped_expected.size() != 0) &&
			guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	// Runs out whatever envelope is still going so that the block is idle.
	task automatic close_envelope();
		int rest;
		settle();
		while (env_on) begin
			rest = phase_len(env_step) - int'(env_count);
			for (int k = int'(env_step) + 1; k < 4; k++)
				rest += phase_len(2'(k));
			repeat (rest) push_item(pick_sample(), 1'b0);
			settle();
		end
	endtask

	// Register write; the model takes the value at once since the block is idle.
	task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_ATTACK_SAMPLES: env_cfg.attack_samples = data[LEN_W-1:0];
			REG_DECAY_SAMPLES: env_cfg.decay_samples = data[LEN_W-1:0];
			REG_SUSTAIN_SAMPLES: env_cfg.sustain_samples = data[LEN_W-1:0];
			REG_RELEASE_SAMPLES: env_cfg.release_samples = data[LEN_W-1:0];
			REG_PEAK_LEVEL: env_cfg.peak_level = data[PEAK_W-1:0];
			REG_ATTACK_SLOPE: env_cfg.attack_slope = data[SLOPE_W-1:0];
			REG_DECAY_SLOPE: env_cfg.decay_slope = data[DSLOPE_W-1:0];
			REG_RELEASE_SLOPE: env_cfg.release_slope = data[SLOPE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly short phases; some zero or overlong values that truncate to short ones.
	function automatic logic [CFG_DATA_W-1:0] pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 16)
			return 25'd1;
		if (r < 26)
			return {9'($urandom), 16'($urandom_range(0, 6))};
		if (r < 34)
			return 25'($urandom_range(10, 40));
		return 25'($urandom_range(1, 9));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_peak();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return '0;
		if (r < 30)
			return '1;
		if (r < 55)
			return 25'(int'(LEVEL_ONE) - 200000 + int'($urandom_range(400000)));
		return 25'($urandom);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_slope();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return '0;
		if (r < 30)
			return 25'hFFFFFF;
		if (r < 60)
			return 25'($urandom_range(0, 1 << 21));
		return 25'($urandom);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_decay_slope();
		int r;
		int d;
		r = $urandom_range(99);
		if (r < 15)
			return 25'h1000000;
		if (r < 30)
			return 25'h0FFFFFF;
		if (r < 60) begin
			d = $urandom_range(0, 1 << 21);
			if ($urandom_range(1))
				d = -d;
			return 25'(d);
		end
		return 25'($urandom);
	endfunction

	task automatic draw_settings();
		write_register(REG_ATTACK_SAMPLES, pick_length());
		write_register(REG_DECAY_SAMPLES, pick_length());
		write_register(REG_SUSTAIN_SAMPLES, pick_length());
		write_register(REG_RELEASE_SAMPLES, pick_length());
		write_register(REG_PEAK_LEVEL, pick_peak());
		write_register(REG_ATTACK_SLOPE, pick_slope());
		write_register(REG_DECAY_SLOPE, pick_decay_slope());
		write_register(REG_RELEASE_SLOPE, pick_slope());
		end_writes();
	endtask

	// One random block: new settings, then whole envelopes with noise between them,
	// some cut short by a note start.
	task automatic run_random_phase(int p);
		int total;
		int count;
		case (p % 4)
			0: begin send_idle_pct = 0; recv_stall_pct = 0; end
			1: begin send_idle_pct = 50; recv_stall_pct = 0; end
			2: begin send_idle_pct = 0; recv_stall_pct = 50; end
			default: begin send_idle_pct = 29; recv_stall_pct = 29; end
		endcase
		draw_settings();
		total = phase_len(PH_ATTACK) + phase_len(PH_DECAY) + phase_len(PH_SUSTAIN) +
			phase_len(PH_RELEASE);
		repeat ($urandom_range(1, 3)) begin
			if ($urandom_range(99) < 15)
				repeat ($urandom_range(1, 3)) push_item(pick_sample(), 1'b0);
			count = ($urandom_range(99) < 12) ? $urandom_range(1, total) : total;
			push_item(pick_sample(), 1'b1);
			repeat (count - 1) push_item(pick_sample(), 1'b0);
		end
		close_envelope();
	endtask

	// Global limit on the run.
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	// Stimulus sequence.
	initial begin
		int phase_no;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: short phases with the reset level and slopes. The attack
		// length has bits above the counter width and sustain is zero long.
		write_register(REG_ATTACK_SAMPLES, 25'h10002);
		write_register(REG_DECAY_SAMPLES, 25'd2);
		write_register(REG_SUSTAIN_SAMPLES, 25'd0);
		write_register(REG_RELEASE_SAMPLES, 25'd3);
		end_writes();
		push_item(S_MAX, 1'b0);
		push_item(S_MIN, 1'b1);
		push_item(S_MAX, 1'b0);
		push_item(S_MAX, 1'b0);
		push_item(S_MIN, 1'b0);
		push_item(-16'sd1, 1'b0);
		push_item(16'sd1, 1'b0);
		push_item(16'sd0, 1'b0);
		push_item(16'sd12345, 1'b0);
		push_item(-16'sd12345, 1'b0);
		push_item(16'sd1000, 1'b1);
		push_item(16'sd2000, 1'b0);
		// A note start in the middle of the decay restarts the envelope.
		push_item(-16'sd1000, 1'b1);
		repeat (7) push_item(pick_sample(), 1'b0);
		close_envelope();

		// Receiver holds off for a long stretch while the sender keeps offering.
		write_register(REG_ATTACK_SAMPLES, 25'd12);
		write_register(REG_DECAY_SAMPLES, 25'd12);
		write_register(REG_SUSTAIN_SAMPLES, 25'd12);
		write_register(REG_RELEASE_SAMPLES, 25'd12);
		write_register(REG_PEAK_LEVEL, pick_peak());
		write_register(REG_ATTACK_SLOPE, pick_slope());
		write_register(REG_DECAY_SLOPE, pick_decay_slope());
		write_register(REG_RELEASE_SLOPE, pick_slope());
		end_writes();
		@(negedge clk);
		hold_request = 1'b1;
		push_item(pick_sample(), 1'b1);
		repeat (47) push_item(pick_sample(), 1'b0);
		close_envelope();

		// Random part.
		phase_no = 0;
		while (shaped_total < RESULT_GOAL) begin
			run_random_phase(phase_no);
			phase_no++;
		end

		// Longest lengths and the steepest attack: the level saturates at its top.
		send_idle_pct = 29;
		recv_stall_pct = 29;
		write_register(REG_ATTACK_SAMPLES, 25'hFFFF);
		write_register(REG_DECAY_SAMPLES, 25'hFFFF);
		write_register(REG_SUSTAIN_SAMPLES, 25'hFFFF);
		write_register(REG_RELEASE_SAMPLES, 25'hFFFF);
		write_register(REG_PEAK_LEVEL, '1);
		write_register(REG_ATTACK_SLOPE, 25'hFFFFFF);
		write_register(REG_DECAY_SLOPE, 25'h1000000);
		write_register(REG_RELEASE_SLOPE, 25'hFFFFFF);
		end_writes();
		push_item(pick_sample(), 1'b1);
		repeat (150) push_item(pick_sample(), 1'b0);
		settle();

		if (shaped_expected.size() != 0)
			report_fault($sformatf("%0d expected items never arrived",
				shaped_expected.size()));
		if (fault_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
